>>> src/sine_tone_generator_macros.svh
// assertion macros for the tone generator rtl
// depends on a clock named clock and a reset named reset in the including scope
`ifndef SINE_TONE_GENERATOR_MACROS_SVH
`define SINE_TONE_GENERATOR_MACROS_SVH

// property that must hold at every clock edge out of reset
`define STE_ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define STE_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> src/ste_pkg.sv
// shared constants, types and the cordic angle table of the tone generator
// no dependencies
package ste_pkg;

   localparam int PHASE_FRACTION_BITS = 24;
   localparam int CORDIC_STEPS        = 16;
   localparam int OUTPUT_BITS         = 16;

   localparam int FREQ_W     = 20;
   localparam int RATE_W     = 20;
   localparam int DUR_W      = 8;
   localparam int COUNT_W    = 24;
   localparam int INDEX_W    = RATE_W + DUR_W;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [1:0] {
      CSR_TONE_FREQUENCY   = 2'd0,
      CSR_SAMPLE_RATE      = 2'd1,
      CSR_DURATION_SECONDS = 2'd2,
      CSR_SAMPLE_COUNT     = 2'd3
   } csr_index_type;

   localparam int TURN_W      = 32;
   localparam int DIV_NUM_W   = (PHASE_FRACTION_BITS > FREQ_W) ? PHASE_FRACTION_BITS : FREQ_W;
   localparam int DIV_COUNT_W = $clog2(DIV_NUM_W + 1);

   localparam int XY_W        = 33;
   localparam int Z_W         = 34;
   localparam int ATAN_IDX_W  = 5;
   localparam logic signed [XY_W-1:0] CORDIC_X_INIT = XY_W'(652032874);
   localparam logic [ATAN_IDX_W-1:0] CORDIC_LAST = ATAN_IDX_W'(CORDIC_STEPS - 1);

   localparam int SCALE_W     = OUTPUT_BITS - 1;
   localparam int PROD_W      = XY_W + SCALE_W;
   localparam int ROUND_SHIFT = 30;
   localparam int ROUNDED_W   = PROD_W + 1 - ROUND_SHIFT;
   localparam logic [SCALE_W-1:0] OUT_SCALE = '1;
   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (ROUND_SHIFT - 1);

   typedef struct packed {
      logic                   start;
      logic [RATE_W-1:0]      rem_init;
      logic [DIV_NUM_W-1:0]   numer;
      logic [DIV_COUNT_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [RATE_W-1:0]    remainder;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD_START,
      ST_MOD_RUN,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_COR_START,
      ST_COR_RUN,
      ST_SCALE,
      ST_FINISH
   } seq_state_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [TURN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [TURN_W-1:0] val;
      unique case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10680862;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41721;
         5'd15:   val = 32'd20860;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2607;
         5'd19:   val = 32'd1303;
         5'd20:   val = 32'd651;
         5'd21:   val = 32'd325;
         5'd22:   val = 32'd162;
         5'd23:   val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> src/ste_if.sv
// valid/ready channels of the tone generator: tick requests and sample responses
// depends on ste_pkg
interface ste_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface ste_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ste_pkg::OUTPUT_BITS-1:0] pcm_sample;
   logic                                   last;

   modport source (output valid, output pcm_sample, output last, input ready);
   modport sink (input valid, input pcm_sample, input last, output ready);
endinterface

>>> src/sine_tone_generator.sv
// Sine tone generator: every request beat yields one response beat carrying a signed
// sample of sin(2*pi*f*n/rate) scaled by 2^(OUTPUT_BITS-1)-1, with last set on the final
// sample of the tone, after which phase and sample index rewind. One beat is handled at a
// time, and ready stays low from each acceptance until its sample is loaded into the
// response register: a restoring divider turns the exact phase residue into a turn
// fraction at one bit a cycle, then a cordic rotates once per cycle. The first beat
// after reset or after any register write also waits while the same divider reduces
// the frequency modulo the sample rate. Any register write, or restart in a request
// beat, sends the tone back to sample zero. A finished sample waits in the response
// register, so the next request is taken while it is still unread.
// depends on ste_pkg, ste_if, ste_divider, ste_cordic and sine_tone_generator_macros.svh
`include "sine_tone_generator_macros.svh"

module sine_tone_generator (
   input  logic                              clock,
   input  logic                              reset,
   ste_req_if.sink                           req_bus,
   ste_rsp_if.source                         rsp_bus,
   input  logic                              csr_wr_en,
   input  ste_pkg::csr_index_type            csr_index,
   input  logic [ste_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   ste_pkg::seq_state_type state_ff, state_in;

   logic [ste_pkg::FREQ_W-1:0]  freq_ff, freq_in;
   logic [ste_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic [ste_pkg::DUR_W-1:0]   dur_ff, dur_in;
   logic [ste_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [ste_pkg::RATE_W-1:0]  phase_ff, phase_in;
   logic [ste_pkg::INDEX_W-1:0] index_ff, index_in;
   logic [ste_pkg::RATE_W-1:0]  step_ff, step_in;
   logic                        stale_ff, stale_in;
   logic [ste_pkg::INDEX_W-1:0] len_ff, len_in;
   logic [ste_pkg::PROD_W-1:0]  product_ff, product_in;
   logic                        neg_ff, neg_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [ste_pkg::OUTPUT_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        req_ready;
   logic                        req_accept;
   logic                        out_free;
   logic                        rsp_load;
   logic [ste_pkg::RATE_W-1:0]  rate_eff;
   logic [ste_pkg::INDEX_W-1:0] len_prod;
   logic [ste_pkg::INDEX_W-1:0] len_calc;

   ste_pkg::div_req_type        div_req;
   ste_pkg::div_rsp_type        div_rsp;
   logic                        cor_start;
   logic                        cor_done;
   logic signed [ste_pkg::XY_W-1:0] cor_y;
   logic [ste_pkg::TURN_W-1:0]  turn;
   logic signed [ste_pkg::Z_W-1:0] turn_ext;
   logic signed [ste_pkg::Z_W-1:0] z_fold;
   logic [ste_pkg::XY_W-1:0]    mag;

   logic [ste_pkg::PROD_W:0]        round_sum;
   logic [ste_pkg::ROUNDED_W-1:0]   rounded;
   logic [ste_pkg::SCALE_W-1:0]     mag_clip;
   logic signed [ste_pkg::OUTPUT_BITS-1:0] sample_val;
   logic [ste_pkg::INDEX_W:0]       index_plus;
   logic                            last_val;
   logic [ste_pkg::RATE_W:0]        phase_sum;
   logic [ste_pkg::RATE_W-1:0]      phase_adv;

   // arithmetic units
   ste_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .divisor (rate_eff),
      .div_rsp (div_rsp)
   );

   ste_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cor_start),
      .z_init (z_fold),
      .done   (cor_done),
      .y_out  (cor_y)
   );

   // handshake
   assign req_accept = req_bus.valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ste_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = stale_ff ? ste_pkg::ST_MOD_START : ste_pkg::ST_DIV_START;
            end
         end
         ste_pkg::ST_MOD_START: state_in = ste_pkg::ST_MOD_RUN;
         ste_pkg::ST_MOD_RUN: begin
            if (div_rsp.done) begin
               state_in = ste_pkg::ST_DIV_START;
            end
         end
         ste_pkg::ST_DIV_START: state_in = ste_pkg::ST_DIV_RUN;
         ste_pkg::ST_DIV_RUN: begin
            if (div_rsp.done) begin
               state_in = ste_pkg::ST_COR_START;
            end
         end
         ste_pkg::ST_COR_START: state_in = ste_pkg::ST_COR_RUN;
         ste_pkg::ST_COR_RUN: begin
            if (cor_done) begin
               state_in = ste_pkg::ST_SCALE;
            end
         end
         ste_pkg::ST_SCALE: state_in = ste_pkg::ST_FINISH;
         ste_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = ste_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready        = 1'b0;
      cor_start        = 1'b0;
      rsp_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.rem_init = '0;
      div_req.numer    = '0;
      div_req.steps    = ste_pkg::DIV_COUNT_W'(ste_pkg::PHASE_FRACTION_BITS);
      unique case (state_ff)
         ste_pkg::ST_IDLE: req_ready = 1'b1;
         ste_pkg::ST_MOD_START: begin
            div_req.start = 1'b1;
            div_req.numer = ste_pkg::DIV_NUM_W'(freq_ff)
                            << (ste_pkg::DIV_NUM_W - ste_pkg::FREQ_W);
            div_req.steps = ste_pkg::DIV_COUNT_W'(ste_pkg::FREQ_W);
         end
         ste_pkg::ST_DIV_START: begin
            div_req.start    = 1'b1;
            div_req.rem_init = phase_ff;
         end
         ste_pkg::ST_COR_START: cor_start = 1'b1;
         ste_pkg::ST_FINISH: rsp_load = out_free;
         default: ;
      endcase
   end

   // effective rate and tone length
   always_comb begin
      rate_eff = (rate_ff == '0) ? ste_pkg::RATE_W'(1) : rate_ff;
      len_prod = ste_pkg::INDEX_W'(rate_eff) * ste_pkg::INDEX_W'(dur_ff);
      len_calc = (count_ff != '0) ? ste_pkg::INDEX_W'(count_ff) : len_prod;
      if (len_calc == '0) begin
         len_calc = ste_pkg::INDEX_W'(1);
      end
   end

   // fold the turn into a quarter turn either way
   always_comb begin
      turn     = ste_pkg::TURN_W'(div_rsp.quotient[ste_pkg::PHASE_FRACTION_BITS-1:0])
                 << (ste_pkg::TURN_W - ste_pkg::PHASE_FRACTION_BITS);
      turn_ext = signed'(ste_pkg::Z_W'(turn));
      unique case (turn[ste_pkg::TURN_W-1 -: 2])
         2'b00:        z_fold = turn_ext;
         2'b01, 2'b10: z_fold = (ste_pkg::Z_W'(1) << (ste_pkg::TURN_W - 1)) - turn_ext;
         default:      z_fold = turn_ext - (ste_pkg::Z_W'(1) << ste_pkg::TURN_W);
      endcase
   end

   // scale, round half away from zero, clip
   always_comb begin
      mag        = cor_y[ste_pkg::XY_W-1] ? ste_pkg::XY_W'(-cor_y) : ste_pkg::XY_W'(cor_y);
      round_sum  = {1'b0, product_ff} + ste_pkg::ROUND_HALF;
      rounded    = round_sum[ste_pkg::PROD_W:ste_pkg::ROUND_SHIFT];
      mag_clip   = (rounded > ste_pkg::ROUNDED_W'(ste_pkg::OUT_SCALE)) ?
                   ste_pkg::OUT_SCALE : rounded[ste_pkg::SCALE_W-1:0];
      sample_val = neg_ff ? -signed'({1'b0, mag_clip}) : signed'({1'b0, mag_clip});
   end

   // phase and index advance
   always_comb begin
      index_plus = {1'b0, index_ff} + (ste_pkg::INDEX_W + 1)'(1);
      last_val   = index_plus >= {1'b0, len_ff};
      phase_sum  = {1'b0, phase_ff} + {1'b0, step_ff};
      if (phase_sum >= {1'b0, rate_eff}) begin
         phase_sum = phase_sum - {1'b0, rate_eff};
      end
      phase_adv = phase_sum[ste_pkg::RATE_W-1:0];
   end

   always_comb begin
      freq_in       = freq_ff;
      rate_in       = rate_ff;
      dur_in        = dur_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      index_in      = index_ff;
      step_in       = step_ff;
      stale_in      = stale_ff;
      len_in        = len_ff;
      product_in    = product_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;

      if (req_accept) begin
         len_in = len_calc;
         if (req_bus.restart) begin
            phase_in = '0;
            index_in = '0;
         end
      end

      if (state_ff == ste_pkg::ST_MOD_RUN && div_rsp.done) begin
         step_in  = div_rsp.remainder;
         stale_in = 1'b0;
      end

      if (state_ff == ste_pkg::ST_SCALE) begin
         product_in = ste_pkg::PROD_W'(mag) * ste_pkg::PROD_W'(ste_pkg::OUT_SCALE);
         neg_in     = cor_y[ste_pkg::XY_W-1];
      end

      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = sample_val;
         rsp_last_in   = last_val;
         if (last_val) begin
            phase_in = '0;
            index_in = '0;
         end else begin
            phase_in = phase_adv;
            index_in = index_plus[ste_pkg::INDEX_W-1:0];
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            ste_pkg::CSR_TONE_FREQUENCY:   freq_in  = csr_wr_data[ste_pkg::FREQ_W-1:0];
            ste_pkg::CSR_SAMPLE_RATE:      rate_in  = csr_wr_data[ste_pkg::RATE_W-1:0];
            ste_pkg::CSR_DURATION_SECONDS: dur_in   = csr_wr_data[ste_pkg::DUR_W-1:0];
            ste_pkg::CSR_SAMPLE_COUNT:     count_in = csr_wr_data[ste_pkg::COUNT_W-1:0];
         endcase
         phase_in = '0;
         index_in = '0;
         stale_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ste_pkg::ST_IDLE;
         freq_ff      <= ste_pkg::FREQ_W'(440);
         rate_ff      <= ste_pkg::RATE_W'(44100);
         dur_ff       <= ste_pkg::DUR_W'(1);
         count_ff     <= '0;
         phase_ff     <= '0;
         index_ff     <= '0;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         freq_ff      <= freq_in;
         rate_ff      <= rate_in;
         dur_ff       <= dur_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      len_ff        <= len_in;
      product_ff    <= product_in;
      neg_ff        <= neg_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_bus.ready      = req_ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pcm_sample = rsp_sample_ff;
   assign rsp_bus.last       = rsp_last_ff;

   // checks
   `STE_ASSERT_CLK(a_busy_after_beat, req_accept |=> !req_ready, "request taken while busy")
   `STE_ASSERT_CLK(a_restart_rewinds, (req_accept && req_bus.restart) |=> (phase_ff == '0 && index_ff == '0), "restart did not rewind tone")
   `STE_ASSERT_CLK(a_last_rewinds, (rsp_load && last_val) |=> (phase_ff == '0 && index_ff == '0), "last sample did not rewind tone")
   `STE_ASSERT_NEVER(a_cordic_done_stray, cor_done && state_ff != ste_pkg::ST_COR_RUN, "cordic finished outside its wait state")

endmodule

>>> src/ste_divider.sv
// restoring divider, one quotient bit a cycle, shared by the step reduction
// and the phase to turn conversion; depends on ste_pkg
module ste_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  ste_pkg::div_req_type          div_req,
   input  logic [ste_pkg::RATE_W-1:0]    divisor,
   output ste_pkg::div_rsp_type          div_rsp
);

   logic [ste_pkg::RATE_W-1:0]      rem_ff, rem_in;
   logic [ste_pkg::DIV_NUM_W-1:0]   numer_ff, numer_in;
   logic [ste_pkg::DIV_NUM_W-1:0]   quot_ff, quot_in;
   logic [ste_pkg::DIV_COUNT_W-1:0] count_ff, count_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [ste_pkg::RATE_W:0] shifted;
   logic [ste_pkg::RATE_W:0] diff;
   logic                     fits;
   logic [ste_pkg::RATE_W-1:0] rem_next;

   always_comb begin
      shifted  = {rem_ff, numer_ff[ste_pkg::DIV_NUM_W-1]};
      fits     = shifted >= {1'b0, divisor};
      diff     = shifted - {1'b0, divisor};
      rem_next = fits ? diff[ste_pkg::RATE_W-1:0] : shifted[ste_pkg::RATE_W-1:0];
   end

   always_comb begin
      rem_in   = rem_ff;
      numer_in = numer_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in   = div_req.rem_init;
         numer_in = div_req.numer;
         quot_in  = '0;
         count_in = div_req.steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = rem_next;
         numer_in = numer_ff << 1;
         quot_in  = {quot_ff[ste_pkg::DIV_NUM_W-2:0], fits};
         count_in = count_ff - ste_pkg::DIV_COUNT_W'(1);
         if (count_ff == ste_pkg::DIV_COUNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      numer_ff <= numer_in;
      quot_ff  <= quot_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;
   assign div_rsp.quotient  = quot_ff;

endmodule

>>> src/ste_cordic.sv
// iterative rotation-mode cordic, one micro-rotation a cycle, sine output on y
// depends on ste_pkg for widths, gain constant and angle table
module ste_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [ste_pkg::Z_W-1:0]    z_init,
   output logic                              done,
   output logic signed [ste_pkg::XY_W-1:0]   y_out
);

   logic signed [ste_pkg::XY_W-1:0]  x_ff, x_in;
   logic signed [ste_pkg::XY_W-1:0]  y_ff, y_in;
   logic signed [ste_pkg::Z_W-1:0]   z_ff, z_in;
   logic [ste_pkg::ATAN_IDX_W-1:0]   step_ff, step_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   logic signed [ste_pkg::XY_W-1:0] dx;
   logic signed [ste_pkg::XY_W-1:0] dy;
   logic signed [ste_pkg::Z_W-1:0]  angle;

   always_comb begin
      dx    = y_ff >>> step_ff;
      dy    = x_ff >>> step_ff;
      angle = signed'(ste_pkg::Z_W'(ste_pkg::atan_turn(step_ff)));
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = ste_pkg::CORDIC_X_INIT;
         y_in    = '0;
         z_in    = z_init;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[ste_pkg::Z_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - angle;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + angle;
         end
         if (step_ff == ste_pkg::CORDIC_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + ste_pkg::ATAN_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign y_out = y_ff;

endmodule

>>> tb/tone_sample_checker.sv
`timescale 1ns / 100ps
// tone_sample_checker: follows tick, sample and register beats of the tone generator,
// works out every sample from its own copy of the settings, phase and index and compares
// depends on ste_pkg
module tone_sample_checker
   import ste_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_restart,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [OUTPUT_BITS-1:0] rsp_pcm_sample,
   input  logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  csr_index_type                 csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wr_data,
   output int                            fail_count,
   output int                            samples_pending,
   output int                            samples_checked,
   output int                            tone_ends
);

   typedef struct packed {
      logic signed [OUTPUT_BITS-1:0] pcm;
      logic                          last;
   } sample_beat_type;

   // atan(2^-i) in 2^-32 turn
   localparam longint ARC_TURNS [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10680862, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41721, 20860, 10430, 5215,
      2607, 1303, 651, 325, 162, 81
   };

   logic [FREQ_W-1:0]  tone_freq;
   logic [RATE_W-1:0]  tone_rate;
   logic [DUR_W-1:0]   tone_secs;
   logic [COUNT_W-1:0] tone_samples;
   longint unsigned    residue;
   longint unsigned    sample_no;
   sample_beat_type    expected_samples [$];
   sample_beat_type    want;

   function automatic logic signed [OUTPUT_BITS-1:0] sine_sample(
      input longint unsigned phase, input longint unsigned rate);
      longint unsigned frac;
      longint unsigned turn;
      longint          z;
      longint          x;
      longint          y;
      longint          dx;
      longint          dy;
      longint          mag;
      longint          rounded;
      longint          scale;
      int              step;
      frac = (phase << PHASE_FRACTION_BITS) / rate;
      turn = (frac << (32 - PHASE_FRACTION_BITS)) & 64'hFFFF_FFFF;
      // fold onto a quarter turn either side of zero
      if (turn < (64'd1 << 30))
         z = longint'(turn);
      else if (turn < (64'd3 << 30))
         z = (64'sd1 <<< 31) - longint'(turn);
      else
         z = longint'(turn) - (64'sd1 <<< 32);
      x = 652032874;
      y = 0;
      for (step = 0; step < CORDIC_STEPS && step < 24; step++) begin
         dx = y >>> step;
         dy = x >>> step;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARC_TURNS[step];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARC_TURNS[step];
         end
      end
      scale = (64'sd1 <<< (OUTPUT_BITS - 1)) - 1;
      mag = (y < 0) ? -y : y;
      rounded = (mag * scale + (64'sd1 <<< 29)) >>> 30;
      if (rounded > scale)
         rounded = scale;
      if (y < 0)
         rounded = -rounded;
      return OUTPUT_BITS'(rounded);
   endfunction

   function automatic sample_beat_type next_sample(input logic restart_bit);
      longint unsigned rate;
      longint unsigned tone_len;
      sample_beat_type beat;
      rate = (tone_rate == '0) ? 64'd1 : 64'(tone_rate);
      tone_len = (tone_samples != '0) ? 64'(tone_samples) : rate * 64'(tone_secs);
      if (tone_len == 0)
         tone_len = 1;
      if (restart_bit) begin
         residue = 0;
         sample_no = 0;
      end
      if (residue >= rate)
         residue = residue % rate;
      beat.pcm = sine_sample(residue, rate);
      beat.last = (sample_no + 1 >= tone_len);
      if (beat.last) begin
         residue = 0;
         sample_no = 0;
      end else begin
         residue = residue + 64'(tone_freq) % rate;
         if (residue >= rate)
            residue = residue - rate;
         sample_no = (sample_no + 1) & 64'hFFF_FFFF;
      end
      return beat;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tone_freq = FREQ_W'(440);
         tone_rate = RATE_W'(44100);
         tone_secs = DUR_W'(1);
         tone_samples = '0;
         residue = 0;
         sample_no = 0;
         expected_samples.delete();
         fail_count = 0;
         samples_checked = 0;
         tone_ends = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TONE_FREQUENCY:   tone_freq = csr_wr_data[FREQ_W-1:0];
               CSR_SAMPLE_RATE:      tone_rate = csr_wr_data[RATE_W-1:0];
               CSR_DURATION_SECONDS: tone_secs = csr_wr_data[DUR_W-1:0];
               CSR_SAMPLE_COUNT:     tone_samples = csr_wr_data[COUNT_W-1:0];
               default: ;
            endcase
            residue = 0;
            sample_no = 0;
         end
         if (req_valid && req_ready)
            expected_samples.push_back(next_sample(req_restart));
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("sample beat with no tick outstanding: pcm_sample %0d, last %0b",
                      rsp_pcm_sample, rsp_last);
               fail_count++;
            end else begin
               want = expected_samples.pop_front();
               samples_checked++;
               if (want.last)
                  tone_ends++;
               if (rsp_pcm_sample !== want.pcm) begin
                  $error("pcm_sample: expected %0d, got %0d", want.pcm, rsp_pcm_sample);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      samples_pending = expected_samples.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// tb: top of the tone generator testbench; drives tick beats and register writes, paces
// the sample channel and gives the verdict from the sample checker beside the block
// depends on ste_pkg, ste_if, sine_tone_generator and tone_sample_checker
module tb;
   import ste_pkg::*;

   localparam int TICKS_RANDOM  = 1500;
   localparam int SETTLE_CYCLES = 80;
   localparam int MAX_GAP       = 17;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    fail_count;
   int                    samples_pending;
   int                    samples_checked;
   int                    tone_ends;
   int                    ticks_sent;
   int                    settings_applied;
   bit                    tx_steady;
   bit                    rx_steady;
   logic [RATE_W-1:0]     rate_now;

   ste_req_if req_bus ();
   ste_rsp_if rsp_bus ();

   sine_tone_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   tone_sample_checker sample_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_restart     (req_bus.restart),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_pcm_sample  (rsp_bus.pcm_sample),
      .rsp_last        (rsp_bus.last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .samples_pending (samples_pending),
      .samples_checked (samples_checked),
      .tone_ends       (tone_ends)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do
         @(negedge clock);
      while (samples_pending != 0);
   endtask

   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
   endtask

   // narrow registers get random bits above their width
   task automatic program_tone(input logic [3:0] which, input logic [FREQ_W-1:0] freq,
                               input logic [RATE_W-1:0] rate, input logic [DUR_W-1:0] secs,
                               input logic [COUNT_W-1:0] count);
      settle();
      if (which[0])
         put_reg(CSR_TONE_FREQUENCY, {4'($urandom), freq});
      if (which[1]) begin
         put_reg(CSR_SAMPLE_RATE, {4'($urandom), rate});
         rate_now = rate;
      end
      if (which[2])
         put_reg(CSR_DURATION_SECONDS, {16'($urandom), secs});
      if (which[3])
         put_reg(CSR_SAMPLE_COUNT, count);
      csr_wr_en <= 1'b0;
      settings_applied++;
   endtask

   task automatic send_tick(input logic restart_bit);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.restart <= restart_bit;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      ticks_sent++;
   endtask

   // sample channel back-pressure
   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         hold = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
         if (hold != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   initial begin
      logic [3:0]         which;
      logic [FREQ_W-1:0]  freq;
      logic [RATE_W-1:0]  rate;
      logic [RATE_W-1:0]  base;
      logic [DUR_W-1:0]   secs;
      logic [COUNT_W-1:0] count;
      int                 ticks_goal;
      int                 phase_len;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.restart = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_TONE_FREQUENCY;
      csr_wr_data = '0;
      ticks_sent = 0;
      settings_applied = 0;
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      rate_now = RATE_W'(44100);
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, restart in mid tone
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      // quarter turns and a five sample tone that wraps
      program_tone(4'b1111, 1, 4, 0, 5);
      repeat (6) send_tick(1'b0);
      // zero sample rate
      program_tone(4'b0010, 0, 0, 0, 0);
      repeat (2) send_tick(1'b0);
      // frequency above the rate
      program_tone(4'b0011, '1, 1000, 0, 0);
      repeat (3) send_tick(1'b0);
      // every register at its top
      program_tone(4'b1111, '1, '1, '1, '1);
      repeat (2) send_tick(1'b0);
      // zero tone length
      program_tone(4'b1100, 0, 0, 0, 0);
      repeat (3) send_tick(1'b0);

      ticks_goal = ticks_sent + TICKS_RANDOM;
      while (ticks_sent < ticks_goal) begin
         which = 4'($urandom_range(1, 15));
         case ($urandom_range(0, 9))
            0:       rate = '0;
            1:       rate = RATE_W'(1);
            2, 3, 4: rate = RATE_W'($urandom_range(2, 16));
            5:       rate = '1;
            default: rate = RATE_W'($urandom);
         endcase
         base = which[1] ? rate : rate_now;
         case ($urandom_range(0, 7))
            0:       freq = '0;
            1:       freq = base - 1'b1;
            2:       freq = base;
            3:       freq = base + 1'b1;
            4:       freq = '1;
            5, 6:    freq = FREQ_W'($urandom_range(1, 64));
            default: freq = FREQ_W'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0:       secs = '0;
            1:       secs = '1;
            2:       secs = DUR_W'(1);
            default: secs = DUR_W'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0, 1:          count = '0;
            2:             count = '1;
            3, 4, 5, 6, 7: count = COUNT_W'($urandom_range(1, 40));
            default:       count = COUNT_W'($urandom);
         endcase
         program_tone(which, freq, rate, secs, count);
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(8, 60);
         repeat (phase_len) begin
            if ($urandom_range(0, 99) == 0)
               hold_until_drained();
            send_tick($urandom_range(0, 15) == 0);
         end
      end

      settle();
      $display("covered %0d ticks under %0d register settings: %0d samples compared, %0d tone ends",
               ticks_sent, settings_applied, samples_checked, tone_ends);
      if (fail_count == 0 && samples_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
